/* rtl/shpd_pkg.sv */
// Package with the constants and types of the sync-header packet deframer.
`default_nettype none

package shpd_pkg;

    localparam int LINES_PER_PACKET_DEFAULT = 5;
    localparam int WORDS_PER_LINE_DEFAULT   = 8;

    localparam logic [15:0] BUFFER_LEN_RESET = 16'd4096;

    localparam logic [7:0] SYNC_FIRST     = 8'hAA;
    localparam logic [7:0] SYNC_SECOND    = 8'h5A;
    localparam logic [7:0] HALF_CODE_ZERO = 8'd36;
    localparam logic [7:0] HALF_CODE_ONE  = 8'd37;

    localparam int HEADER_BYTES = 32;

    localparam logic [4:0] OFFSET_ID        = 5'd2;
    localparam logic [4:0] OFFSET_HALF      = 5'd3;
    localparam logic [4:0] OFFSET_STAMP_LO  = 5'd16;
    localparam logic [4:0] OFFSET_STAMP_HI  = 5'd19;
    localparam logic [4:0] OFFSET_HEADER_END = 5'd31;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_BAD_HALF = 2'd1,
        KIND_SHORT    = 2'd2
    } kind_t;

endpackage

`default_nettype wire

/* rtl/sync_header_packet_deframer_core.sv */
// Sync-header packet deframer: byte input, tagged 32-bit word and error output.
//
// Bytes enter on the input channel (in_valid, in_stall, data_byte, packet_start); a
// transfer with packet_start high is byte zero of a new packet and restarts the sync
// search. Results leave on the output channel (out_valid, out_stall and the result
// fields), one per data word and one per error, with last_word high on the final
// word of a packet and on every error.
// A transferred byte is held in an input register and is then decoded into the result
// register; a stall holds the byte in the input register until the result register is free.
// One byte is taken every cycle as long as the receiver keeps taking results; the
// single-pass decode between the two registers sets that rate.
// When the receiver stalls, the result register holds, an empty input register takes one
// more byte and in_stall then rises until the result is taken. The buffer length is
// written through cfg_wr_en and cfg_wr_data by the user while the block is idle; unchecked.
// Reset clears the decode state, sets the buffer length to 4096 and empties both registers.
`default_nettype none

module sync_header_packet_deframer_core
    import shpd_pkg::*;
#(
    parameter int LINES_PER_PACKET = LINES_PER_PACKET_DEFAULT,
    parameter int WORDS_PER_LINE   = WORDS_PER_LINE_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        packet_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [3:0]       fpga_id,
    output logic [3:0]       asic_id,
    output logic             half_index,
    output logic [2:0]       line_index,
    output logic [2:0]       word_index,
    output logic [31:0]      word_value,
    output logic [31:0]      timestamp_low,
    output logic             last_word
);

    localparam int LINE_BYTES   = 4 * WORDS_PER_LINE;
    localparam int NEEDED_BYTES = HEADER_BYTES + LINE_BYTES * LINES_PER_PACKET;

    localparam logic [16:0] NEEDED      = 17'(NEEDED_BYTES);
    localparam logic [5:0]  LINE_LAST   = 6'(LINE_BYTES);
    localparam logic [3:0]  LINES_LIMIT = 4'(LINES_PER_PACKET);
    localparam logic [3:0]  WORDS_LIMIT = 4'(WORDS_PER_LINE);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_start_reg;

    logic [15:0] size_reg;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  prev_reg;
    phase_t      phase_reg, phase_next;
    logic [4:0]  offset_reg, offset_next;
    logic [3:0]  fpga_reg, fpga_next;
    logic [3:0]  asic_reg, asic_next;
    logic        half_reg, half_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [23:0] assembly_reg, assembly_next;
    logic [2:0]  line_reg, line_next;

    logic        out_valid_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [3:0]  fpga_out_reg, fpga_out_next;
    logic [3:0]  asic_out_reg, asic_out_next;
    logic        half_out_reg, half_out_next;
    logic [2:0]  line_out_reg, line_out_next;
    logic [2:0]  word_out_reg, word_out_next;
    logic [31:0] value_out_reg, value_out_next;
    logic [31:0] stamp_out_reg, stamp_out_next;
    logic        last_out_reg, last_out_next;
    logic        result_next;

    logic        load_ok;
    logic        s1_fire;
    logic        in_fire;

    assign load_ok  = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && load_ok;
    assign in_stall = s1_valid_reg && !load_ok;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        logic [15:0] q;
        phase_t      ph;
        logic [7:0]  b;
        logic [4:0]  off;
        logic [2:0]  word;

        b   = s1_byte_reg;
        q   = s1_start_reg ? 16'd0 : pos_reg;
        ph  = s1_start_reg ? PH_SEARCH : phase_reg;
        off = offset_reg;
        word = off[4:2];

        pos_next      = (q != 16'hFFFF) ? q + 16'd1 : q;
        phase_next    = ph;
        offset_next   = offset_reg;
        fpga_next     = fpga_reg;
        asic_next     = asic_reg;
        half_next     = half_reg;
        stamp_next    = stamp_reg;
        assembly_next = assembly_reg;
        line_next     = line_reg;

        result_next    = 1'b0;
        kind_next      = KIND_DATA;
        fpga_out_next  = 4'd0;
        asic_out_next  = 4'd0;
        half_out_next  = 1'b0;
        line_out_next  = 3'd0;
        word_out_next  = 3'd0;
        value_out_next = 32'd0;
        stamp_out_next = 32'd0;
        last_out_next  = 1'b1;

        case (ph)
            PH_SEARCH:
            begin
                if (q != 16'd0 && prev_reg == SYNC_FIRST && b == SYNC_SECOND &&
                    ({1'b0, q} - 17'd1 + NEEDED) <= {1'b0, size_reg})
                begin
                    phase_next  = PH_HEADER;
                    offset_next = OFFSET_ID;
                end
                else if (({1'b0, q} + NEEDED) > {1'b0, size_reg})
                begin
                    result_next = 1'b1;
                    kind_next   = KIND_SHORT;
                    phase_next  = PH_DONE;
                end
            end
            PH_HEADER:
            begin
                if (off == OFFSET_ID)
                begin
                    fpga_next = b[7:4];
                    asic_next = b[3:0];
                end
                else if (off == OFFSET_HALF)
                begin
                    if (b == HALF_CODE_ZERO)
                    begin
                        half_next = 1'b0;
                    end
                    else if (b == HALF_CODE_ONE)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        result_next   = 1'b1;
                        kind_next     = KIND_BAD_HALF;
                        fpga_out_next = fpga_reg;
                        asic_out_next = asic_reg;
                        phase_next    = PH_DONE;
                    end
                end
                else if (off >= OFFSET_STAMP_LO && off <= OFFSET_STAMP_HI)
                begin
                    stamp_next[8 * off[1:0] +: 8] = b;
                end
                if (phase_next == PH_HEADER)
                begin
                    if (off >= OFFSET_HEADER_END)
                    begin
                        phase_next    = PH_DATA;
                        offset_next   = 5'd0;
                        line_next     = 3'd0;
                        assembly_next = 24'd0;
                    end
                    else
                    begin
                        offset_next = off + 5'd1;
                    end
                end
            end
            PH_DATA:
            begin
                if (off[1:0] != 2'd3)
                begin
                    assembly_next[8 * off[1:0] +: 8] = b;
                end
                else
                begin
                    result_next    = 1'b1;
                    kind_next      = KIND_DATA;
                    fpga_out_next  = fpga_reg;
                    asic_out_next  = asic_reg;
                    half_out_next  = half_reg;
                    line_out_next  = line_reg;
                    word_out_next  = word;
                    value_out_next = {b, assembly_reg};
                    stamp_out_next = stamp_reg;
                    last_out_next  = ({1'b0, line_reg} + 4'd1 >= LINES_LIMIT) &&
                                     ({1'b0, word} + 4'd1 >= WORDS_LIMIT);
                    assembly_next  = 24'd0;
                end
                if ({1'b0, off} + 6'd1 >= LINE_LAST)
                begin
                    offset_next = 5'd0;
                    if ({1'b0, line_reg} + 4'd1 >= LINES_LIMIT)
                    begin
                        phase_next = PH_DONE;
                        line_next  = 3'd0;
                    end
                    else
                    begin
                        line_next = line_reg + 3'd1;
                    end
                end
                else
                begin
                    offset_next = off + 5'd1;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= BUFFER_LEN_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= 16'd0;
            prev_reg      <= 8'd0;
            phase_reg     <= PH_SEARCH;
            offset_reg    <= 5'd0;
            fpga_reg      <= 4'd0;
            asic_reg      <= 4'd0;
            half_reg      <= 1'b0;
            stamp_reg     <= 32'd0;
            assembly_reg  <= 24'd0;
            line_reg      <= 3'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (load_ok)
            begin
                out_valid_reg <= s1_fire && result_next;
            end
            if (s1_fire)
            begin
                pos_reg      <= pos_next;
                prev_reg     <= s1_byte_reg;
                phase_reg    <= phase_next;
                offset_reg   <= offset_next;
                fpga_reg     <= fpga_next;
                asic_reg     <= asic_next;
                half_reg     <= half_next;
                stamp_reg    <= stamp_next;
                assembly_reg <= assembly_next;
                line_reg     <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg  <= data_byte;
            s1_start_reg <= packet_start;
        end
        if (s1_fire && result_next)
        begin
            kind_reg      <= kind_next;
            fpga_out_reg  <= fpga_out_next;
            asic_out_reg  <= asic_out_next;
            half_out_reg  <= half_out_next;
            line_out_reg  <= line_out_next;
            word_out_reg  <= word_out_next;
            value_out_reg <= value_out_next;
            stamp_out_reg <= stamp_out_next;
            last_out_reg  <= last_out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign fpga_id       = fpga_out_reg;
    assign asic_id       = asic_out_reg;
    assign half_index    = half_out_reg;
    assign line_index    = line_out_reg;
    assign word_index    = word_out_reg;
    assign word_value    = value_out_reg;
    assign timestamp_low = stamp_out_reg;
    assign last_word     = last_out_reg;

endmodule

`default_nettype wire
